/* sv/simon_128_128_block_encrypt_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Simon 128/128 encrypt block
// Concurrent checks on clk, disabled while rst is high; empty when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef SIMON_128_128_BLOCK_ENCRYPT_ASSERT_SVH
`define SIMON_128_128_BLOCK_ENCRYPT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SIMON_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("simon128 check failed");
// next-cycle implication
`define SIMON_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("simon128 check failed");
`else
`define SIMON_ASSERT_NOW(lbl, ante, cons)
`define SIMON_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/simon128_pkg.sv */
// ----------------------------------------------------------------------------
// simon128_pkg
// Shared types and constants for the Simon 128/128 encrypt pipeline.
// ----------------------------------------------------------------------------
package simon128_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned ROUNDS = 68;
  localparam int unsigned Z2_LEN = 62;
  localparam int unsigned ADDR_W = 4;

  // z2 sequence, entry 0 first
  localparam logic [0:Z2_LEN-1] Z2_SEQ =
    62'b10101111_01110000_00110100_10011000_10100001_00011111_10010110_110011;

  localparam logic [WORD_W-1:0] KS_CONST = 64'hFFFF_FFFF_FFFF_FFFC;

  // register index, decoded from paddr[3]
  localparam logic REG_KEY_LO = 1'b0;
  localparam logic REG_KEY_HI = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] plain_hi;
    logic [WORD_W-1:0] plain_lo;
  } plain_t;

  typedef struct packed {
    logic [WORD_W-1:0] cipher_hi;
    logic [WORD_W-1:0] cipher_lo;
  } cipher_t;

  // one pipeline slot: Feistel halves plus the two live round keys
  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] ka;
    logic [WORD_W-1:0] kb;
  } stage_t;

  typedef struct packed {
    logic [WORD_W-1:0] key_lo;
    logic [WORD_W-1:0] key_hi;
  } key_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned s);
    rotl = (v << s) | (v >> (WORD_W - s));
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                             input int unsigned s);
    rotr = (v >> s) | (v << (WORD_W - s));
  endfunction

endpackage

/* sv/simon128_regs.sv */
// ----------------------------------------------------------------------------
// simon128_regs
// APB key register file: key_lo at 0x0, key_hi at 0x8.
// ----------------------------------------------------------------------------
module simon128_regs
  import simon128_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready,
  output key_t              key
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key.key_lo <= '0;
      key.key_hi <= '0;
    end else if (wr) begin
      unique case (paddr[3])
        REG_KEY_LO: key.key_lo <= pwdata;
        REG_KEY_HI: key.key_hi <= pwdata;
        default:    key.key_lo <= key.key_lo;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_KEY_LO: prdata = key.key_lo;
      REG_KEY_HI: prdata = key.key_hi;
      default:    prdata = '0;
    endcase
  end

endmodule

/* sv/simon128_stage.sv */
// ----------------------------------------------------------------------------
// simon128_stage
// One registered Feistel round plus one key schedule step.
// ----------------------------------------------------------------------------
module simon128_stage
  import simon128_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   zbit,
  input  logic   prev_valid,
  input  stage_t prev,
  output logic   valid,
  output stage_t data
);

  stage_t            data_next;
  logic [WORD_W-1:0] r;

  always_comb begin
    r = rotr(prev.kb, 3);
    data_next.x  = prev.y ^ (rotl(prev.x, 1) & rotl(prev.x, 8)) ^ rotl(prev.x, 2)
                   ^ prev.ka;
    data_next.y  = prev.x;
    data_next.ka = prev.kb;
    data_next.kb = (KS_CONST ^ {{(WORD_W-1){1'b0}}, zbit}) ^ prev.ka ^ r ^ rotr(r, 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

/* sv/simon128_skid.sv */
// ----------------------------------------------------------------------------
// simon128_skid
// Output register with one spare entry; upstream ready is a flop.
// ----------------------------------------------------------------------------
module simon128_skid
  import simon128_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  input  cipher_t up_data,
  output logic    up_ready,
  output logic    out_valid,
  output cipher_t out_data,
  input  logic    out_ready
);

  `include "simon_128_128_block_encrypt_assert.svh"

  logic    spare_valid;
  cipher_t spare_data;
  logic    push;
  logic    drain;

  assign up_ready = !spare_valid;
  assign push     = up_valid && up_ready;
  assign drain    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (drain) begin
      out_valid   <= spare_valid || push;
      spare_valid <= 1'b0;
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data <= spare_valid ? spare_data : up_data;
    end
    if (!drain && push) begin
      spare_data <= up_data;
    end
  end

  // spare fills only behind a held output
  `SIMON_ASSERT_NOW(a_spare_behind_out, spare_valid, out_valid)
  // a transaction arriving against a stalled output lands in the spare
  `SIMON_ASSERT_NEXT(a_stall_to_spare, push && out_valid && !out_ready, spare_valid)
  // spare drains first when the receiver takes
  `SIMON_ASSERT_NEXT(a_spare_drains, spare_valid && out_ready, !spare_valid && out_valid)

endmodule

/* sv/simon_128_128_block_encrypt.sv */
// ----------------------------------------------------------------------------
// simon_128_128_block_encrypt
// Simon 128/128 ECB encryption, fully unrolled round pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   plain_valid/plain_ready/plain_data carry one 128-bit block per
//   transaction; cipher_valid/cipher_ready/cipher_data return its
//   ciphertext, one result per block, in order.
//   The key is written over APB: key_lo at 0x0, key_hi at 0x8 (64-bit
//   data). Write it only while no block is in flight.
//   A block accepted on plain_* passes through one register stage per
//   round, then the output register, before it shows on cipher_data.
//   Throughput: one block per cycle while cipher_ready stays high. Each
//   stage carries its own copy of the two live round keys, so the schedule
//   advances alongside the data and no key table is needed.
//   Stall: when cipher_ready drops, one more transaction moves into a
//   spare entry behind the output register; then plain_ready (a flop)
//   falls and the whole round pipeline holds. Nothing is dropped or
//   repeated.
//   Reset (rst, synchronous): clears all stage valids, the output and spare
//   valids and both key words.
// ----------------------------------------------------------------------------
module simon_128_128_block_encrypt
  import simon128_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // block input
  input  logic              plain_valid,
  output logic              plain_ready,
  input  plain_t            plain_data,
  // block output
  output logic              cipher_valid,
  input  logic              cipher_ready,
  output cipher_t           cipher_data,
  // APB key port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready
);

  `include "simon_128_128_block_encrypt_assert.svh"

  key_t          key;
  logic          pipe_en;
  logic [ROUNDS:0] sv;
  stage_t        st [0:ROUNDS];
  cipher_t       last_data;

  simon128_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key)
  );

  // stage 0 input: left half is the high word, keys k[0], k[1]
  assign sv[0]    = plain_valid;
  assign st[0].x  = plain_data.plain_hi;
  assign st[0].y  = plain_data.plain_lo;
  assign st[0].ka = key.key_lo;
  assign st[0].kb = key.key_hi;

  assign plain_ready = pipe_en;

  // round i uses z2 bit (i mod 62) when producing k[i+2]
  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    localparam logic ZB = Z2_SEQ[i % Z2_LEN];
    simon128_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .en         (pipe_en),
      .zbit       (ZB),
      .prev_valid (sv[i]),
      .prev       (st[i]),
      .valid      (sv[i+1]),
      .data       (st[i+1])
    );
  end

  assign last_data.cipher_hi = st[ROUNDS].x;
  assign last_data.cipher_lo = st[ROUNDS].y;

  // pipe_en is the skid's registered ready: the pipeline advances
  // whenever the spare entry is free
  simon128_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (sv[ROUNDS]),
    .up_data   (last_data),
    .up_ready  (pipe_en),
    .out_valid (cipher_valid),
    .out_data  (cipher_data),
    .out_ready (cipher_ready)
  );

  // a held pipeline keeps its valid pattern
  `SIMON_ASSERT_NEXT(a_hold_valids, !pipe_en, $stable(sv[ROUNDS:1]))
  // an accepted block occupies the first stage next cycle
  `SIMON_ASSERT_NEXT(a_enter_first, plain_valid && pipe_en, sv[1])

endmodule
